// ===== rtl/core/cbf_pkg.sv =====
// Shared types and codes for the circular byte FIFO.
// No dependencies; imported by the controller, datapath and top level.
package cbf_pkg;

    // Operation codes
    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_PEEK     = 3'd2;
    localparam logic [2:0] OP_READ_RUN = 3'd3;
    localparam logic [2:0] OP_POP_RUN  = 3'd4;
    localparam logic [2:0] OP_SKIP_RUN = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Longest run emitted for one item
    localparam int unsigned MAX_RUN = 64;

    // Controller -> datapath
    typedef struct packed {
        logic accept;      // input item taken this cycle
        logic fetch_take;  // fetched byte moves into the output register
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;    // output register empty or draining this cycle
        logic needs_read;  // current input item reads the ring
        logic run_more;    // bytes remain after the one being taken
    } dp_status_t;

endpackage

// ===== rtl/core/cbf_ctrl.sv =====
// Controller for the circular byte FIFO: idle/fetch state machine.
// Depends on cbf_pkg; drives the datapath through ctrl_cmd_t.
module cbf_ctrl import cbf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        s_ready        = (state_reg == S_IDLE) && stat.out_free;
        cmd.accept     = s_ready && s_valid;
        cmd.fetch_take = (state_reg == S_FETCH) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && stat.needs_read) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                if (cmd.fetch_take && !stat.run_more) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/cbf_dp.sv =====
// Datapath for the circular byte FIFO: ring memory, pointers, level,
// run sequencing and the output register. Depends on cbf_pkg.
module cbf_dp import cbf_pkg::*; #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_value,
    input  logic [11:0] s_offset,
    input  logic [6:0]  s_count,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  stat,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [7:0]  m_data,
    output logic [1:0]  m_status,
    output logic [6:0]  m_done_count,
    output logic        m_last,
    output logic [12:0] m_fill_level,
    output logic        m_is_empty,
    output logic        m_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = (CW > 13) ? CW : 13;
    localparam int SW = VW + 1;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b,
                                           input logic [SW-1:0] d,
                                           input logic [CW-1:0] cap);
        logic [SW-1:0] s;
        s = SW'(b) + d;
        if (s >= SW'(cap)) begin
            s = s - SW'(cap);
        end
        return AW'(s);
    endfunction

    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q;
    logic       mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;

    logic [CW-1:0] cap_reg, cap_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] level_reg, level_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [6:0]    rem_reg, rem_next;
    logic [6:0]    run_reg, run_next;

    logic          valid_reg, valid_next;
    logic [7:0]    data_reg, data_next;
    logic [1:0]    status_reg, status_next;
    logic [6:0]    done_reg, done_next;
    logic          last_reg, last_next;
    logic [12:0]   fill_reg, fill_next;
    logic          empty_reg, empty_next;
    logic          full_reg, full_next;
    logic          out_load;

    // Item decode
    logic [VW-1:0] level_v, off_v, avail_v;
    logic [6:0]    clip_cnt, run_n;
    logic          ring_empty, ring_full, off_ok;
    logic [1:0]    direct_st;
    logic [6:0]    direct_done;
    logic          need_rd;
    logic [AW-1:0] rd_start;

    assign level_v    = VW'(level_reg);
    assign off_v      = VW'(s_offset);
    assign ring_empty = (level_reg == '0);
    assign ring_full  = (level_reg >= cap_reg);
    assign off_ok     = (off_v < level_v);
    assign clip_cnt   = (s_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : s_count;
    assign avail_v    = (s_operation == OP_READ_RUN) ? (level_v - off_v) : level_v;
    assign run_n      = (VW'(clip_cnt) > avail_v) ? avail_v[6:0] : clip_cnt;

    always_comb begin
        need_rd     = 1'b0;
        rd_start    = head_reg;
        direct_st   = ST_NONE;
        direct_done = '0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        level_next  = level_reg;
        mem_we      = 1'b0;
        mem_waddr   = tail_reg;
        run_next    = run_reg;
        case (s_operation)
            OP_PUSH: begin
                if (ring_full) begin
                    direct_st = ST_FULL;
                end else begin
                    direct_st   = ST_OK;
                    direct_done = 7'd1;
                    mem_we      = cmd.accept;
                    tail_next   = wrap(tail_reg, SW'(1), cap_reg);
                    level_next  = level_reg + CW'(1);
                end
            end
            OP_POP: begin
                if (!ring_empty) begin
                    need_rd    = 1'b1;
                    run_next   = 7'd1;
                    head_next  = wrap(head_reg, SW'(1), cap_reg);
                    level_next = level_reg - CW'(1);
                end
            end
            OP_PEEK, OP_READ_RUN: begin
                if (ring_empty) begin
                    direct_st = ST_NONE;
                end else if (!off_ok) begin
                    direct_st = ST_RANGE;
                end else if (s_operation == OP_PEEK || run_n != '0) begin
                    need_rd  = 1'b1;
                    rd_start = wrap(head_reg, SW'(s_offset), cap_reg);
                    run_next = (s_operation == OP_PEEK) ? 7'd1 : run_n;
                end
            end
            OP_POP_RUN: begin
                if (run_n != '0) begin
                    need_rd    = 1'b1;
                    run_next   = run_n;
                    head_next  = wrap(head_reg, SW'(run_n), cap_reg);
                    level_next = level_reg - CW'(run_n);
                end
            end
            OP_SKIP_RUN: begin
                if (run_n != '0) begin
                    direct_st   = ST_OK;
                    direct_done = run_n;
                    head_next   = wrap(head_reg, SW'(run_n), cap_reg);
                    level_next  = level_reg - CW'(run_n);
                end
            end
            default: direct_st = ST_NONE;
        endcase
    end

    always_comb begin
        stat.out_free   = !valid_reg || m_ready;
        stat.needs_read = need_rd;
        stat.run_more   = (rem_reg != 7'd1);
    end

    // Capacity, read pointer, run and output register updates
    always_comb begin
        cap_next    = cap_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        mem_re      = 1'b0;
        mem_raddr   = pos_reg;
        out_load    = 1'b0;
        data_next   = data_reg;
        status_next = status_reg;
        done_next   = done_reg;
        last_next   = last_reg;
        fill_next   = fill_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;

        if (cmd.accept) begin
            if (need_rd) begin
                mem_re    = 1'b1;
                mem_raddr = rd_start;
                pos_next  = wrap(rd_start, SW'(1), cap_reg);
                rem_next  = run_next;
            end else begin
                out_load    = 1'b1;
                data_next   = '0;
                status_next = direct_st;
                done_next   = direct_done;
                last_next   = 1'b1;
                fill_next   = 13'(level_next);
                empty_next  = (level_next == '0);
                full_next   = (level_next == cap_reg);
            end
        end else if (cmd.fetch_take) begin
            out_load    = 1'b1;
            data_next   = mem_q;
            status_next = ST_OK;
            done_next   = (rem_reg == 7'd1) ? run_reg : 7'd0;
            last_next   = (rem_reg == 7'd1);
            fill_next   = 13'(level_reg);
            empty_next  = (level_reg == '0);
            full_next   = (level_reg == cap_reg);
            rem_next    = rem_reg - 7'd1;
            if (rem_reg != 7'd1) begin
                mem_re    = 1'b1;
                mem_raddr = pos_reg;
                pos_next  = wrap(pos_reg, SW'(1), cap_reg);
            end
        end

        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                cap_next = CW'(1);
            end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
                cap_next = CW'(DEPTH);
            end else begin
                cap_next = CW'(cfg_wdata);
            end
        end

        valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_value;
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CW'(DEPTH);
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            cap_reg   <= cap_next;
            valid_reg <= valid_next;
            if (cfg_we) begin
                head_reg  <= '0;
                tail_reg  <= '0;
                level_reg <= '0;
            end else if (cmd.accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        rem_reg    <= rem_next;
        if (cmd.accept) begin
            run_reg <= run_next;
        end
        data_reg   <= data_next;
        status_reg <= status_next;
        done_reg   <= done_next;
        last_reg   <= last_next;
        fill_reg   <= fill_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
    end

    assign m_valid      = valid_reg;
    assign m_data       = data_reg;
    assign m_status     = status_reg;
    assign m_done_count = done_reg;
    assign m_last       = last_reg;
    assign m_fill_level = fill_reg;
    assign m_is_empty   = empty_reg;
    assign m_is_full    = full_reg;

endmodule

// ===== rtl/core/circular_byte_fifo_with_slice.sv =====
// Top level of the circular byte FIFO with run (slice) operations.
// Depends on cbf_pkg, cbf_ctrl and cbf_dp.
//
// Usage
//   Input channel s_*: one item is one operation (push, pop, peek, read run,
//   pop run, skip run) with its value, offset and count fields.
//   Result channel m_*: one item per byte read, or one status item for
//   operations that read nothing; m_last marks the final item of an
//   operation, and m_done_count carries the bytes handled on that item.
//   cfg_we/cfg_wdata set the ring's capacity in use (clamped to 1..DEPTH)
//   and empty the ring; write only while the block is idle.
// Timing
//   Push, skip and status-only operations: result registered straight into
//   the output register. Pop and peek: the byte passes the registered read
//   port of the ring memory, then the output register. Runs: one byte per
//   cycle out of that same read port, unless m_ready holds the output.
// Reset
//   aresetn (synchronous, active low) empties the ring and sets the capacity
//   to DEPTH; no clearing pass is needed, as a slot is only read after a write.
// Backpressure
//   The single output register holds while m_ready is low; a new item or the
//   next run byte is taken in the cycle the held item drains.
module circular_byte_fifo_with_slice import cbf_pkg::*; #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_value,
    input  logic [11:0] s_offset,
    input  logic [6:0]  s_count,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data,
    output logic [1:0]  m_status,
    output logic [6:0]  m_done_count,
    output logic        m_last,
    output logic [12:0] m_fill_level,
    output logic        m_is_empty,
    output logic        m_is_full
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // Sequencer: idle, or fetching bytes of a read
    cbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Ring memory, pointers and output register
    cbf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_offset     (s_offset),
        .s_count      (s_count),
        .cmd          (cmd),
        .stat         (stat),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_data       (m_data),
        .m_status     (m_status),
        .m_done_count (m_done_count),
        .m_last       (m_last),
        .m_fill_level (m_fill_level),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full)
    );

`ifndef SYNTH
    // A read that was started blocks new items on the next cycle
    a_fetch_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.needs_read) |=> !s_ready)
        else $error("input taken while a read is in flight");

    // Only the final item of an operation carries a byte count
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_done_count == 7'd0 && m_status == ST_OK))
        else $error("count or error status on a non-final item");

    // Empty flag agrees with the level
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_fill_level == 13'd0)))
        else $error("empty flag disagrees with fill level");
`endif

endmodule
